// File: rtl/core/mtp_pkg.sv
`timescale 1ns / 1ps

package mtp_pkg;

    // Default tape geometry.
    localparam int P_SECTOR_COUNT = 254;
    localparam int P_SECTOR_BYTES = 543;
    localparam int P_HEADER_BYTES = 15;

    // Fixed field widths.
    localparam int KIND_W  = 2;
    localparam int PORT_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int LOAD_W  = 18;
    localparam int COUNT_W = 10;
    localparam int GAP_W   = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    // Writes are stored only once the byte counter has passed the preamble.
    localparam logic [COUNT_W:0]   WR_SKIP   = 11'd12;
    localparam logic [GAP_W-1:0]   GAP_INIT  = 4'd15;

    localparam logic [BYTE_W-1:0] BYTE_ERASED = 8'hFF;
    localparam logic [BYTE_W-1:0] STAT_GAP    = 8'hFE;
    localparam logic [BYTE_W-1:0] STAT_SYNC   = 8'hF8;
    localparam logic [BYTE_W-1:0] MOTOR_ONE   = 8'h01;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_CARTRIDGE = 1'b0;
    localparam logic REG_PROTECT   = 1'b1;

    // Output queue depth.
    localparam int Q_DEPTH = 3;
    localparam int Q_PW    = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_RESET = 2'd2,
        KIND_LOAD  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SEL_DATA    = 2'd0,
        SEL_CTRL    = 2'd1,
        SEL_REALIGN = 2'd2,
        SEL_NONE    = 2'd3
    } t_sel;

    typedef struct packed {
        logic              save;
        logic [BYTE_W-1:0] data;
    } t_out_word;

endpackage

// File: rtl/core/mtp_ram.sv
`timescale 1ns / 1ps

module mtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/core/mtp_out_queue.sv
`timescale 1ns / 1ps

module mtp_out_queue
    import mtp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_out_word       i_word,
    input  logic            i_ready,
    output logic            o_valid,
    output t_out_word       o_word,
    output logic [Q_PW-1:0] o_count
);

    t_out_word       r_q [Q_DEPTH];
    logic [Q_PW-1:0] r_wr_ptr;
    logic [Q_PW-1:0] r_rd_ptr;
    logic [Q_PW-1:0] r_cnt;
    logic            pop;

    assign o_valid = (r_cnt != '0);
    assign o_word  = r_q[r_rd_ptr];
    assign o_count = r_cnt;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/microdrive_tape_port_controller.sv
`timescale 1ns / 1ps

// Looped-tape cartridge drive seen through CPU I/O port accesses. One word enters on the
// slave stream per access and exactly one word leaves on the master stream for it, in
// order. The block takes a new word every cycle unless the erase runs or the stage and
// output queue already hold three words. Each result passes the stage register, beside
// the registered tape memory read, then a three-entry output queue that absorbs stalls
// on the master side. The tape lives in a single byte-wide memory with one write and one
// registered read port. After reset the block erases the whole tape to 0xFF, one byte
// per cycle, so s_axis_tready stays low until all SECTOR_COUNT * SECTOR_BYTES bytes
// (137922 at the default geometry) are erased; the APB registers can be written meanwhile.
module microdrive_tape_port_controller
    import mtp_pkg::*;
#(
    parameter int SECTOR_COUNT = P_SECTOR_COUNT,
    parameter int SECTOR_BYTES = P_SECTOR_BYTES,
    parameter int HEADER_BYTES = P_HEADER_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Slave stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: port[15:0], value[23:16], load_address[41:24], zero fill up to 47.
    input  logic [47:0]       s_axis_tdata,
    // tuser: kind[1:0].
    input  logic [1:0]        s_axis_tuser,
    // Master stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // tdata: read_data[7:0], save_request[8], zero fill up to 15.
    output logic [15:0]       m_axis_tdata,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int TAPE_BYTES = SECTOR_COUNT * SECTOR_BYTES;
    localparam int ADDR_W     = $clog2(TAPE_BYTES);
    localparam int OFF_W      = $clog2(SECTOR_BYTES);
    localparam int SEC_W      = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;

    // Input fields.
    t_kind              in_kind;
    logic [PORT_W-1:0]  in_port;
    logic [BYTE_W-1:0]  in_value;
    logic [LOAD_W-1:0]  in_load;
    t_sel               in_sel;
    logic               accept;

    assign in_kind  = t_kind'(s_axis_tuser);
    assign in_port  = s_axis_tdata[15:0];
    assign in_value = s_axis_tdata[23:16];
    assign in_load  = s_axis_tdata[41:24];
    assign in_sel   = t_sel'(in_port[4:3]);

    // Drive state.
    logic [SEC_W-1:0]   r_head_sec,  n_head_sec;
    logic [OFF_W-1:0]   r_head_off,  n_head_off;
    logic [ADDR_W-1:0]  r_head_pos,  n_head_pos;
    logic [COUNT_W-1:0] r_byte_cnt,  n_byte_cnt;
    logic [COUNT_W-1:0] r_block_lim, n_block_lim;
    logic [GAP_W-1:0]   r_gap,       n_gap;
    logic [GAP_W-1:0]   r_nogap,     n_nogap;
    logic [BYTE_W-1:0]  r_motor,     n_motor;
    logic               r_last_clk,  n_last_clk;
    logic               r_dirty,     n_dirty;
    logic [BYTE_W-1:0]  r_last_rd;
    logic               r_cart;
    logic               r_protect;

    // Erase sweep.
    logic               r_clr_active;
    logic [ADDR_W-1:0]  r_clr_addr;

    // Stage after acceptance, waiting for the memory read.
    logic               r_s1_valid;
    logic               r_s1_tape;
    logic [BYTE_W-1:0]  r_s1_rd;
    logic               r_s1_save;

    // Memory and queue.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [BYTE_W-1:0]  ram_rdata;
    logic               q_push;
    t_out_word          q_in;
    t_out_word          q_out;
    logic [Q_PW-1:0]    q_count;
    logic [Q_PW:0]      occupancy;

    // Combinational results of the accepted word.
    logic               c_tape_rd;
    logic               c_tape_wr;
    logic [ADDR_W-1:0]  c_wr_addr;
    logic [BYTE_W-1:0]  c_rd;
    logic               c_save;

    // Head movement candidates.
    logic [OFF_W:0]     off_inc;
    logic               sec_last;
    logic [SEC_W-1:0]   sec_inc;
    logic [SEC_W-1:0]   adv_sec, rlg_sec;
    logic [OFF_W-1:0]   adv_off, rlg_off;
    logic [ADDR_W-1:0]  adv_pos, rlg_pos;
    logic [COUNT_W-1:0] rlg_lim;
    logic [COUNT_W-1:0] cnt_bump;
    logic [BYTE_W-1:0]  last_eff;
    logic               live;

    assign live     = (r_motor == MOTOR_ONE) && r_cart;
    assign sec_last = (r_head_sec == SEC_W'(SECTOR_COUNT - 1));
    assign sec_inc  = sec_last ? '0 : r_head_sec + 1'b1;
    assign off_inc  = {1'b0, r_head_off} + 1'b1;
    assign cnt_bump = (r_byte_cnt == COUNT_MAX) ? r_byte_cnt : r_byte_cnt + 1'b1;
    // The previous word may still be fetching the byte that becomes the last read byte.
    assign last_eff = (r_s1_valid && r_s1_tape) ? ram_rdata : r_last_rd;

    always_comb begin
        if (off_inc >= (OFF_W + 1)'(SECTOR_BYTES)) begin
            adv_off = '0;
            adv_sec = sec_inc;
            adv_pos = sec_last ? '0 : r_head_pos + 1'b1;
        end else begin
            adv_off = off_inc[OFF_W-1:0];
            adv_sec = r_head_sec;
            adv_pos = r_head_pos + 1'b1;
        end
    end

    // Realignment moves the head to the start of the next header or data block, unless it already stands at one.
    always_comb begin
        rlg_off = r_head_off;
        rlg_sec = r_head_sec;
        rlg_pos = r_head_pos;
        if (r_head_off != '0 && r_head_off != OFF_W'(HEADER_BYTES)) begin
            if (r_head_off < OFF_W'(HEADER_BYTES)) begin
                rlg_off = OFF_W'(HEADER_BYTES);
                rlg_pos = r_head_pos + ADDR_W'(HEADER_BYTES) - ADDR_W'(r_head_off);
            end else begin
                rlg_off = '0;
                rlg_sec = sec_inc;
                rlg_pos = sec_last ? '0
                        : r_head_pos + ADDR_W'(SECTOR_BYTES) - ADDR_W'(r_head_off);
            end
        end
        rlg_lim = (rlg_off == '0) ? COUNT_W'(HEADER_BYTES)
                                  : COUNT_W'(SECTOR_BYTES - HEADER_BYTES);
    end

    always_comb begin
        n_head_sec  = r_head_sec;
        n_head_off  = r_head_off;
        n_head_pos  = r_head_pos;
        n_byte_cnt  = r_byte_cnt;
        n_block_lim = r_block_lim;
        n_gap       = r_gap;
        n_nogap     = r_nogap;
        n_motor     = r_motor;
        n_last_clk  = r_last_clk;
        n_dirty     = r_dirty;
        c_tape_rd   = 1'b0;
        c_tape_wr   = 1'b0;
        c_wr_addr   = r_head_pos;
        c_rd        = '0;
        c_save      = 1'b0;

        case (in_kind)
            KIND_READ: begin
                c_rd = BYTE_ERASED;
                case (in_sel)
                    SEL_DATA: begin
                        if (live) begin
                            if (r_byte_cnt < r_block_lim) begin
                                c_tape_rd  = 1'b1;
                                n_head_sec = adv_sec;
                                n_head_off = adv_off;
                                n_head_pos = adv_pos;
                            end else begin
                                c_rd = last_eff;
                            end
                            n_byte_cnt = cnt_bump;
                        end
                    end
                    SEL_CTRL: begin
                        if (live) begin
                            if (r_gap != '0) begin
                                c_rd  = STAT_GAP;
                                n_gap = r_gap - 1'b1;
                            end else begin
                                c_rd = STAT_SYNC;
                                if (r_nogap != '0) begin
                                    n_nogap = r_nogap - 1'b1;
                                end else begin
                                    n_gap   = GAP_INIT;
                                    n_nogap = GAP_INIT;
                                end
                            end
                            c_rd[0] = r_protect;
                        end
                        n_head_sec  = rlg_sec;
                        n_head_off  = rlg_off;
                        n_head_pos  = rlg_pos;
                        n_byte_cnt  = '0;
                        n_block_lim = rlg_lim;
                    end
                    SEL_REALIGN: begin
                        n_head_sec  = rlg_sec;
                        n_head_off  = rlg_off;
                        n_head_pos  = rlg_pos;
                        n_byte_cnt  = '0;
                        n_block_lim = rlg_lim;
                    end
                    default: begin
                    end
                endcase
            end
            KIND_WRITE: begin
                case (in_sel)
                    SEL_DATA: begin
                        if (live) begin
                            if ({1'b0, r_byte_cnt} >= WR_SKIP &&
                                {1'b0, r_byte_cnt} < {1'b0, r_block_lim} + WR_SKIP) begin
                                c_tape_wr  = 1'b1;
                                n_head_sec = adv_sec;
                                n_head_off = adv_off;
                                n_head_pos = adv_pos;
                                n_dirty    = 1'b1;
                            end
                            n_byte_cnt = cnt_bump;
                        end
                    end
                    SEL_CTRL: begin
                        // Motor select bits shift in on a falling edge of the clock bit.
                        if (!in_value[1] && r_last_clk) begin
                            n_motor = {r_motor[BYTE_W-2:0], ~in_value[0]};
                            if (r_dirty) begin
                                c_save  = 1'b1;
                                n_dirty = 1'b0;
                            end
                        end
                        n_last_clk  = in_value[1];
                        n_head_sec  = rlg_sec;
                        n_head_off  = rlg_off;
                        n_head_pos  = rlg_pos;
                        n_byte_cnt  = '0;
                        n_block_lim = rlg_lim;
                    end
                    SEL_REALIGN: begin
                        n_head_sec  = rlg_sec;
                        n_head_off  = rlg_off;
                        n_head_pos  = rlg_pos;
                        n_byte_cnt  = '0;
                        n_block_lim = rlg_lim;
                    end
                    default: begin
                    end
                endcase
            end
            KIND_RESET: begin
                n_gap      = GAP_INIT;
                n_nogap    = GAP_INIT;
                n_head_sec = '0;
                n_head_off = '0;
                n_head_pos = '0;
            end
            default: begin
                if ({1'b0, in_load} < (LOAD_W + 1)'(TAPE_BYTES)) begin
                    c_tape_wr = 1'b1;
                    c_wr_addr = in_load[ADDR_W-1:0];
                end
            end
        endcase
    end

    assign occupancy     = {1'b0, q_count} + (Q_PW + 1)'(r_s1_valid);
    assign s_axis_tready = !r_clr_active && (occupancy < (Q_PW + 1)'(Q_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ram_we    = r_clr_active || (accept && c_tape_wr);
    assign ram_waddr = r_clr_active ? r_clr_addr : c_wr_addr;
    assign ram_wdata = r_clr_active ? BYTE_ERASED : in_value;
    assign ram_re    = accept && c_tape_rd;

    mtp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_BYTES)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head_pos),
        .o_rdata (ram_rdata)
    );

    assign q_push    = r_s1_valid;
    assign q_in.save = r_s1_save;
    assign q_in.data = r_s1_tape ? ram_rdata : r_s1_rd;

    mtp_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_word  (q_out),
        .o_count (q_count)
    );

    assign m_axis_tdata = {7'b0, q_out.save, q_out.data};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_tape <= c_tape_rd;
            r_s1_rd   <= c_rd;
            r_s1_save <= c_save;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_sec   <= '0;
            r_head_off   <= '0;
            r_head_pos   <= '0;
            r_byte_cnt   <= '0;
            r_block_lim  <= '0;
            r_gap        <= '0;
            r_nogap      <= '0;
            r_motor      <= '0;
            r_last_clk   <= 1'b0;
            r_dirty      <= 1'b0;
            r_last_rd    <= '0;
            r_s1_valid   <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            if (accept) begin
                r_head_sec  <= n_head_sec;
                r_head_off  <= n_head_off;
                r_head_pos  <= n_head_pos;
                r_byte_cnt  <= n_byte_cnt;
                r_block_lim <= n_block_lim;
                r_gap       <= n_gap;
                r_nogap     <= n_nogap;
                r_motor     <= n_motor;
                r_last_clk  <= n_last_clk;
                r_dirty     <= n_dirty;
            end
            if (r_s1_valid && r_s1_tape) begin
                r_last_rd <= ram_rdata;
            end
            r_s1_valid <= accept;
            if (r_clr_active) begin
                if (r_clr_addr == ADDR_W'(TAPE_BYTES - 1)) begin
                    r_clr_active <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Configuration registers.
    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROTECT) ? APB_DW'(r_protect) : APB_DW'(r_cart);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart    <= 1'b0;
            r_protect <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_CARTRIDGE: r_cart    <= pwdata[0];
                default:       r_protect <= pwdata[0];
            endcase
        end
    end

endmodule
